// ----- design/assert_macros.svh -----
// Assertion macros used by the tracker back end (mft_back).
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/mft_pkg.sv -----
// Shared types and constants of the motor feedback tracker.
// Depends on nothing; used by every module of the tracker.
package mft_pkg;

  localparam int MOTOR_SLOTS = 4;
  localparam int SLOT_W = 2;
  localparam int CNT_W = $clog2(MOTOR_SLOTS + 1);

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [4:0] TYPE_FEEDBACK = 5'h02;
  localparam logic [4:0] TYPE_REPORT = 5'h18;

  localparam logic [23:0] POS_LIMIT_Q16 = 24'd823788;
  localparam logic [15:0] SPEED_DEFAULT_Q88 = 16'd11264;
  localparam logic [15:0] TORQUE_DEFAULT_Q88 = 16'd4352;
  localparam logic [3:0] RETRY_PERIOD = 4'd10;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic [15:0] DIV_CONST = 16'hFFFF;
  localparam logic [15:0] ROUND_HALF = 16'd32767;
  localparam logic [3:0] FULL_FRAME_LEN = 4'd8;

  localparam logic [2:0] KIND_IGNORED = 3'd0;
  localparam logic [2:0] KIND_ONLINE = 3'd1;
  localparam logic [2:0] KIND_FEEDBACK = 3'd2;
  localparam logic [2:0] KIND_REENABLE = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE = 3'd4;

  localparam logic [1:0] WORD_POS = 2'd0;
  localparam logic [1:0] WORD_VEL = 2'd1;
  localparam logic [1:0] WORD_TOR = 2'd2;
  localparam logic [1:0] WORD_END = 2'd3;

  localparam logic [2:0] REG_SLOT_MOTOR_IDS = 3'd0;
  localparam logic [2:0] REG_SLOT_COUNT = 3'd1;
  localparam logic [2:0] REG_ENABLED_MASK = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMITS = 3'd3;
  localparam logic [2:0] REG_TORQUE_LIMITS = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd5;

  typedef struct packed {
    logic              is_tick;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              has_data;
    logic [15:0]       raw_position;
    logic [15:0]       raw_velocity;
    logic [15:0]       raw_torque;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        slot;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] torque;
    logic [3:0]        online_mask;
    logic              last;
  } res_t;

endpackage

// ----- design/mft_front.sv -----
// Front end: takes input beats, decodes frame type and slot match.
// Holds a two-entry command queue toward the back end; uses mft_pkg.
module mft_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      op,
  input  logic [31:0]               frame_id,
  input  logic [3:0]                frame_len,
  input  logic [15:0]               raw_position,
  input  logic [15:0]               raw_velocity,
  input  logic [15:0]               raw_torque,
  input  logic [31:0]               slot_motor_ids,
  input  logic [mft_pkg::CNT_W-1:0] n_active,
  output logic                      cmd_valid,
  output mft_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);

  mft_pkg::cmd_t cls;
  mft_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          do_push;
  logic          do_pop;
  logic          type_ok;
  logic [7:0]    motor;

  always_comb begin
    type_ok = (frame_id[28:24] == mft_pkg::TYPE_FEEDBACK) ||
              (frame_id[28:24] == mft_pkg::TYPE_REPORT);
    motor = frame_id[15:8];
    cls.is_tick = op;
    cls.hit = 1'b0;
    cls.slot = '0;
    cls.has_data = (frame_len >= mft_pkg::FULL_FRAME_LEN);
    cls.raw_position = raw_position;
    cls.raw_velocity = raw_velocity;
    cls.raw_torque = raw_torque;
    for (int i = mft_pkg::MOTOR_SLOTS - 1; i >= 0; i--) begin
      if (!op && type_ok && (mft_pkg::CNT_W'(i) < n_active) &&
          (slot_motor_ids[8*i +: 8] == motor)) begin
        cls.hit = 1'b1;
        cls.slot = mft_pkg::SLOT_W'(i);
      end
    end
  end

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        q[wr_ptr] <= cls;
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- design/mft_scale.sv -----
// Three-stage pipelined scaler: maps a raw word onto +/- limit in Q16.16.
// Divides by 65535 with two folding steps and one correction; uses mft_pkg.
module mft_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_tag,
  input  logic [15:0]        raw,
  input  logic [23:0]        limit,
  output logic               out_valid,
  output logic [1:0]         out_tag,
  output logic signed [31:0] value,
  output logic               busy
);

  logic        va, vb;
  logic [1:0]  tag_a, tag_b;
  logic        neg_a, neg_b;
  logic [39:0] prod_a;
  logic [24:0] q0_b;
  logic [25:0] r_b;
  logic [16:0] two_raw;
  logic [16:0] span;
  logic [40:0] y;
  logic [24:0] q0;
  logic [9:0]  q1;
  logic [16:0] r2;
  logic [24:0] q;

  always_comb begin
    two_raw = {raw, 1'b0};
    span = raw[15] ? (two_raw - {1'b0, mft_pkg::DIV_CONST})
                   : ({1'b0, mft_pkg::DIV_CONST} - two_raw);
    y = {1'b0, prod_a} + {25'd0, mft_pkg::ROUND_HALF};
    q0 = y[40:16];
    q1 = r_b[25:16];
    r2 = {1'b0, r_b[15:0]} + {7'd0, q1};
    q = q0_b + {15'd0, q1} + {24'd0, (r2 >= {1'b0, mft_pkg::DIV_CONST})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
    tag_a <= in_tag;
    neg_a <= !raw[15];
    prod_a <= span[15:0] * limit;
    tag_b <= tag_a;
    neg_b <= neg_a;
    q0_b <= q0;
    r_b <= {10'd0, y[15:0]} + {1'b0, q0};
    out_tag <= tag_b;
    value <= neg_b ? -$signed({7'd0, q}) : $signed({7'd0, q});
  end

  assign busy = va || vb || out_valid;

endmodule

// ----- design/mft_back.sv -----
// Back end: owns slot state, executes frame and tick commands, emits results.
// Uses mft_pkg, mft_scale and the assertion macros.
`include "assert_macros.svh"

module mft_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  mft_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic [mft_pkg::CNT_W-1:0] n_active,
  input  logic [3:0]                enabled_mask,
  input  logic [63:0]               speed_limits,
  input  logic [63:0]               torque_limits,
  input  logic [15:0]               timeout_ticks,
  input  logic                      res_full,
  output logic                      res_push,
  output mft_pkg::res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_FRAME_OUT, S_WALK, S_REQ, S_TICK_OUT
  } state_t;

  state_t                      state;
  mft_pkg::cmd_t               cur;
  logic [mft_pkg::CNT_W-1:0]   idx;
  logic [1:0]                  s_cnt;
  logic [3:0]                  online;
  logic [mft_pkg::MOTOR_SLOTS-1:0] req;
  logic [15:0]                 age [mft_pkg::MOTOR_SLOTS];
  logic [3:0]                  retry [mft_pkg::MOTOR_SLOTS];
  logic signed [31:0]          pos_q, vel_q, tor_q;

  logic [mft_pkg::SLOT_W-1:0]  w;
  logic [15:0]                 age_inc;
  logic                        on_w;
  logic                        want;
  logic                        fire;
  logic [3:0]                  retry_nx;
  logic [15:0]                 spd_sel, trq_sel;
  logic                        sc_in_valid;
  logic [15:0]                 sc_raw;
  logic [23:0]                 sc_limit;
  logic                        sc_out_valid;
  logic [1:0]                  sc_out_tag;
  logic signed [31:0]          sc_value;
  logic                        sc_busy;
  logic                        req_end;

  always_comb begin
    w = idx[mft_pkg::SLOT_W-1:0];
    age_inc = (age[w] == mft_pkg::AGE_MAX) ? age[w] : age[w] + 16'd1;
    on_w = online[w] && !(age_inc > timeout_ticks);
    want = !on_w && enabled_mask[w];
    fire = want && (retry[w] == mft_pkg::RETRY_PERIOD);
    retry_nx = fire ? 4'd0 : (want ? retry[w] + 4'd1 : retry[w]);
    req_end = (idx == mft_pkg::CNT_W'(mft_pkg::MOTOR_SLOTS));
  end

  always_comb begin
    spd_sel = speed_limits[16*cur.slot +: 16];
    trq_sel = torque_limits[16*cur.slot +: 16];
    if (spd_sel == 16'd0) begin
      spd_sel = mft_pkg::SPEED_DEFAULT_Q88;
    end
    if (trq_sel == 16'd0) begin
      trq_sel = mft_pkg::TORQUE_DEFAULT_Q88;
    end
    sc_in_valid = (state == S_SCALE) && (s_cnt != mft_pkg::WORD_END);
    case (s_cnt)
      mft_pkg::WORD_POS: begin
        sc_raw = cur.raw_position;
        sc_limit = mft_pkg::POS_LIMIT_Q16;
      end
      mft_pkg::WORD_VEL: begin
        sc_raw = cur.raw_velocity;
        sc_limit = {spd_sel, 8'd0};
      end
      default: begin
        sc_raw = cur.raw_torque;
        sc_limit = {trq_sel, 8'd0};
      end
    endcase
  end

  mft_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_in_valid),
    .in_tag    (s_cnt),
    .raw       (sc_raw),
    .limit     (sc_limit),
    .out_valid (sc_out_valid),
    .out_tag   (sc_out_tag),
    .value     (sc_value),
    .busy      (sc_busy)
  );

  always_comb begin
    res = '0;
    res.online_mask = online;
    res_push = 1'b0;
    case (state)
      S_FRAME_OUT: begin
        res_push = !res_full;
        res.last = 1'b1;
        if (cur.hit) begin
          res.slot = cur.slot;
          if (cur.has_data) begin
            res.kind = mft_pkg::KIND_FEEDBACK;
            res.position = pos_q;
            res.velocity = vel_q;
            res.torque = tor_q;
          end else begin
            res.kind = mft_pkg::KIND_ONLINE;
          end
        end else begin
          res.kind = mft_pkg::KIND_IGNORED;
        end
      end
      S_REQ: begin
        res.kind = mft_pkg::KIND_REENABLE;
        res.slot = w;
        res_push = !req_end && req[w] && !res_full;
      end
      S_TICK_OUT: begin
        res.kind = mft_pkg::KIND_TICK_DONE;
        res.last = 1'b1;
        res_push = !res_full;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      s_cnt <= mft_pkg::WORD_POS;
      online <= 4'd0;
      req <= '0;
      for (int i = 0; i < mft_pkg::MOTOR_SLOTS; i++) begin
        age[i] <= 16'd0;
        retry[i] <= 4'd0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            s_cnt <= mft_pkg::WORD_POS;
            req <= '0;
            if (cmd.is_tick) begin
              state <= S_WALK;
            end else if (cmd.hit) begin
              online[cmd.slot] <= 1'b1;
              age[cmd.slot] <= 16'd0;
              state <= cmd.has_data ? S_SCALE : S_FRAME_OUT;
            end else begin
              state <= S_FRAME_OUT;
            end
          end
        end
        S_SCALE: begin
          if (sc_in_valid) begin
            s_cnt <= s_cnt + 2'd1;
          end
          if (sc_out_valid) begin
            case (sc_out_tag)
              mft_pkg::WORD_POS: pos_q <= sc_value;
              mft_pkg::WORD_VEL: vel_q <= sc_value;
              default: tor_q <= sc_value;
            endcase
            if (sc_out_tag == mft_pkg::WORD_TOR) begin
              state <= S_FRAME_OUT;
            end
          end
        end
        S_FRAME_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (idx < n_active) begin
            age[w] <= age_inc;
            online[w] <= on_w;
            retry[w] <= retry_nx;
            req[w] <= fire;
            idx <= idx + mft_pkg::CNT_W'(1);
          end else begin
            idx <= '0;
            state <= S_REQ;
          end
        end
        S_REQ: begin
          if (req_end) begin
            state <= S_TICK_OUT;
          end else if (!req[w] || !res_full) begin
            idx <= idx + mft_pkg::CNT_W'(1);
          end
        end
        S_TICK_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMP(a_idle_scaler_empty, state == S_IDLE, !sc_busy)
  `ASSERT_NEXT(a_last_returns_idle, res_push && res.last, state == S_IDLE)
  `ASSERT_IMP(a_walk_in_range, state == S_WALK, idx <= n_active)
  `ASSERT_IMP(a_scale_only_in_scale, sc_out_valid, state == S_SCALE)

endmodule

// ----- design/mft_outq.sv -----
// Four-entry result queue between the back end and the result ports.
// Shows the oldest result while not empty; uses mft_pkg.
module mft_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  mft_pkg::res_t din,
  output logic          full,
  output logic          empty,
  input  logic          rd,
  output mft_pkg::res_t dout
);

  mft_pkg::res_t mem [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    cnt;
  logic          do_wr;
  logic          do_rd;

  assign full = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign dout = mem[rd_ptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (do_wr) begin
        mem[wr_ptr] <= din;
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      cnt <= cnt + {2'd0, do_wr} - {2'd0, do_rd};
    end
  end

endmodule

// ----- design/motor_feedback_tracker.sv -----
// Top level of the motor feedback tracker: configuration registers and wiring.
// Depends on mft_pkg, mft_front, mft_back (with mft_scale) and mft_outq.
//
//   Channel   Handshake            Payload
//   input     push / full          op, frame_id, frame_len, raw_* words
//   result    empty / pop          kind, slot, position, velocity, torque,
//                                  online_mask, last
//   config    cfg_write            cfg_index, cfg_data
//
// A frame beat without data goes from being taken straight to its result; with data,
// the three words first enter the three-stage scaler on consecutive cycles.
// A tick beat is taken, then the walk steps over the active slots, then the
// re-enable requests of all four slots are visited in turn, then the result.
// Synchronous reset clears all slot state and loads register defaults.
// A full result queue stalls the back end; the two-entry front queue fills behind it.
module motor_feedback_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [31:0]        frame_id,
  input  logic [3:0]         frame_len,
  input  logic [15:0]        raw_position,
  input  logic [15:0]        raw_velocity,
  input  logic [15:0]        raw_torque,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         kind,
  output logic [1:0]         slot,
  output logic signed [31:0] position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] torque,
  output logic [3:0]         online_mask,
  output logic               last,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [31:0]               slot_motor_ids;
  logic [2:0]                slot_count;
  logic [3:0]                enabled_mask;
  logic [63:0]               speed_limits;
  logic [63:0]               torque_limits;
  logic [15:0]               timeout_ticks;
  logic [mft_pkg::CNT_W-1:0] n_active;
  logic                      cmd_valid;
  mft_pkg::cmd_t             cmd;
  logic                      cmd_pop;
  logic                      res_full;
  logic                      res_push;
  mft_pkg::res_t             res;
  mft_pkg::res_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_motor_ids <= 32'd0;
      slot_count <= 3'd0;
      enabled_mask <= 4'd0;
      speed_limits <= 64'd0;
      torque_limits <= 64'd0;
      timeout_ticks <= 16'd50;
    end else if (cfg_write) begin
      case (cfg_index)
        mft_pkg::REG_SLOT_MOTOR_IDS: slot_motor_ids <= cfg_data[31:0];
        mft_pkg::REG_SLOT_COUNT: slot_count <= cfg_data[2:0];
        mft_pkg::REG_ENABLED_MASK: enabled_mask <= cfg_data[3:0];
        mft_pkg::REG_SPEED_LIMITS: speed_limits <= cfg_data;
        mft_pkg::REG_TORQUE_LIMITS: torque_limits <= cfg_data;
        mft_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign n_active = ({1'b0, slot_count} > (mft_pkg::CNT_W + 1)'(mft_pkg::MOTOR_SLOTS))
                  ? mft_pkg::CNT_W'(mft_pkg::MOTOR_SLOTS)
                  : mft_pkg::CNT_W'(slot_count);

  mft_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .op             (op),
    .frame_id       (frame_id),
    .frame_len      (frame_len),
    .raw_position   (raw_position),
    .raw_velocity   (raw_velocity),
    .raw_torque     (raw_torque),
    .slot_motor_ids (slot_motor_ids),
    .n_active       (n_active),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  mft_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .n_active      (n_active),
    .enabled_mask  (enabled_mask),
    .speed_limits  (speed_limits),
    .torque_limits (torque_limits),
    .timeout_ticks (timeout_ticks),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res)
  );

  mft_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .din   (res),
    .full  (res_full),
    .empty (empty),
    .rd    (pop),
    .dout  (head)
  );

  assign kind = head.kind;
  assign slot = head.slot;
  assign position = head.position;
  assign velocity = head.velocity;
  assign torque = head.torque;
  assign online_mask = head.online_mask;
  assign last = head.last;

endmodule
